>>> design/bls_pkg.sv
// Package for the binomial 5-tap line smoother.
// Holds the queue entry type, queue sizing and the 1-4-6-4-1 kernel function.
package bls_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SUM_W     = 12;
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_AW      = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW      = $clog2(Q_DEPTH + 1);
  localparam logic [SUM_W-1:0] ROUND = SUM_W'(8);
  localparam int unsigned OUT_SHIFT = 4;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic steady;
    logic prev;
    logic cur;
  } res_mask_t;

  typedef struct packed {
    pix_t      r3;
    pix_t      r2;
    pix_t      r1;
    pix_t      r0;
    pix_t      px;
    res_mask_t mask;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic pix_t kernel(input pix_t a, input pix_t b, input pix_t c,
                                  input pix_t d, input pix_t e);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(a) + (SUM_W'(b) << 2) + (SUM_W'(c) << 2) + (SUM_W'(c) << 1)
        + (SUM_W'(d) << 2) + SUM_W'(e) + ROUND;
    return sum[OUT_SHIFT +: PIX_W];
  endfunction

endpackage

>>> design/bls_front.sv
// Front end: accepts pixels, keeps the line window and position, and queues jobs.
// Depends on bls_pkg for the job type.
module bls_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bls_pkg::pix_t in_pixel_in,
  input  logic          in_line_end,
  input  bls_pkg::q_stat_t q_stat,
  output logic          push,
  output bls_pkg::job_t push_job
);

  logic [1:0]    pos_r, pos_nxt;
  bls_pkg::pix_t win_r [4];
  bls_pkg::pix_t win_nxt [4];
  bls_pkg::pix_t eff [4];
  logic          accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      eff[k] = (pos_r == 2'd0) ? in_pixel_in : win_r[k];
    end
    push_job.r3          = eff[3];
    push_job.r2          = eff[2];
    push_job.r1          = eff[1];
    push_job.r0          = eff[0];
    push_job.px          = in_pixel_in;
    push_job.mask.steady = pos_r >= 2'd2;
    push_job.mask.prev   = in_line_end && (pos_r >= 2'd1);
    push_job.mask.cur    = in_line_end;
    push = accept && (push_job.mask.steady || in_line_end);

    pos_nxt = pos_r;
    for (int k = 0; k < 4; k++) begin
      win_nxt[k] = win_r[k];
    end
    if (accept) begin
      if (in_line_end) begin
        pos_nxt = 2'd0;
        for (int k = 0; k < 4; k++) begin
          win_nxt[k] = '0;
        end
      end else begin
        win_nxt[3] = eff[2];
        win_nxt[2] = eff[1];
        win_nxt[1] = eff[0];
        win_nxt[0] = in_pixel_in;
        if (pos_r != 2'd3) begin
          pos_nxt = pos_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
      for (int k = 0; k < 4; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      pos_r <= pos_nxt;
      for (int k = 0; k < 4; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

endmodule

>>> design/bls_queue.sv
// Short job queue between the front end and the back end.
// Depends on bls_pkg for the job type and queue sizing.
module bls_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bls_pkg::job_t    push_job,
  input  logic             pop,
  output bls_pkg::job_t    head_job,
  output bls_pkg::q_stat_t q_stat
);

  bls_pkg::job_t            mem_r [bls_pkg::Q_DEPTH];
  logic [bls_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bls_pkg::Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bls_pkg::Q_CW-1:0] count_r, count_nxt;
  logic                     do_push, do_pop;

  assign q_stat.full  = count_r == bls_pkg::Q_CW'(bls_pkg::Q_DEPTH);
  assign q_stat.empty = count_r == '0;
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> design/bls_back.sv
// Back end: walks the results of each queued job and drives the output register.
// Depends on bls_pkg for the job type and the kernel function.
module bls_back (
  input  logic             clk,
  input  logic             rst_n,
  input  bls_pkg::job_t    head_job,
  input  bls_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output bls_pkg::pix_t    out_pixel_out,
  output logic             out_last
);

  bls_pkg::res_mask_t done_r, done_nxt;
  bls_pkg::res_mask_t rem, sel, left;
  logic               out_valid_r, out_valid_nxt;
  bls_pkg::pix_t      pix_r, pix_nxt;
  logic               last_r, last_nxt;
  logic               fire;

  assign out_valid     = out_valid_r;
  assign out_pixel_out = pix_r;
  assign out_last      = last_r;

  always_comb begin
    rem  = head_job.mask & ~done_r;
    sel  = '0;
    if (rem.steady) begin
      sel.steady = 1'b1;
    end else if (rem.prev) begin
      sel.prev = 1'b1;
    end else begin
      sel.cur = 1'b1;
    end
    left = rem & ~sel;
    fire = !q_stat.empty && (!out_valid_r || out_ready);
    pop  = fire && (left == '0);

    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pix_nxt       = pix_r;
    last_nxt      = last_r;
    if (fire) begin
      done_nxt      = pop ? bls_pkg::res_mask_t'('0) : (done_r | sel);
      out_valid_nxt = 1'b1;
      last_nxt      = sel.cur;
      if (sel.steady) begin
        pix_nxt = bls_pkg::kernel(head_job.r3, head_job.r2, head_job.r1,
                                  head_job.r0, head_job.px);
      end else if (sel.prev) begin
        pix_nxt = bls_pkg::kernel(head_job.r2, head_job.r1, head_job.r0,
                                  head_job.px, head_job.px);
      end else begin
        pix_nxt = bls_pkg::kernel(head_job.r1, head_job.r0, head_job.px,
                                  head_job.px, head_job.px);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r  <= pix_nxt;
    last_r <= last_nxt;
  end

endmodule

>>> design/binomial_5tap_line_smoother_top.sv
// A result passes through the four-entry job queue and then the output register.
// Throughput: one request per cycle unless the queue is full; a line-end request produces up
// to three results, which the back end emits one per cycle while out_ready is high.
// Reset (rst_n low, synchronous) empties the queue, clears the window and line position,
// and drops any pending result.
module binomial_5tap_line_smoother_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bls_pkg::pix_t in_pixel_in,
  input  logic          in_line_end,
  output logic          out_valid,
  input  logic          out_ready,
  output bls_pkg::pix_t out_pixel_out,
  output logic          out_last
);

  bls_pkg::q_stat_t q_stat;
  bls_pkg::job_t    push_job, head_job;
  logic             push, pop;

  bls_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel_in(in_pixel_in),
    .in_line_end(in_line_end),
    .q_stat     (q_stat),
    .push       (push),
    .push_job   (push_job)
  );

  bls_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head_job(head_job),
    .q_stat  (q_stat)
  );

  bls_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_job     (head_job),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_out(out_pixel_out),
    .out_last     (out_last)
  );

endmodule

>>> design/bls_checker.sv
// Port-level assertions for the binomial 5-tap line smoother.
// Bound to binomial_5tap_line_smoother_top; depends on bls_pkg for the pixel type.
module bls_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input bls_pkg::pix_t in_pixel_in,
  input logic          in_line_end,
  input logic          out_valid,
  input logic          out_ready,
  input bls_pkg::pix_t out_pixel_out,
  input logic          out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out) && $stable(out_last))
    else $error("stalled result changed or vanished");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_pixel_in) && $stable(in_line_end))
    else $error("stalled request changed or vanished");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  a_no_result_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) ##1 !out_valid |=> !out_valid)
    else $error("result without a pending request");

endmodule

bind binomial_5tap_line_smoother_top bls_checker u_bls_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_pixel_in  (in_pixel_in),
  .in_line_end  (in_line_end),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_pixel_out(out_pixel_out),
  .out_last     (out_last)
);
